### src/afk_pkg.sv
// Shared constants and tables of the arm forward kinematics block.
package afk_pkg;

  // CORDIC fraction bits and iteration count
  localparam int ANGLE_BITS = 16;
  // CORDIC datapath width: sign, integer headroom, fraction
  localparam int CW = ANGLE_BITS + 3;
  // width of a cumulative sum of three Q2.13 angles
  localparam int SUM_W = 18;
  localparam int LEN_W = 10;
  localparam int OUT_W = 17;
  localparam int IN_W = 16;

  // product of a link length and a cosine or sine, and the sum of three
  localparam int PROD_W = CW + LEN_W + 1;
  localparam int RS_W = PROD_W + 2;
  localparam int PXY_W = CW + RS_W;

  // pipeline: input, fold, iterations, products, sums, multiply, round/clamp
  localparam int SC_STAGES = ANGLE_BITS + 1;
  localparam int NSTAGES = ANGLE_BITS + 6;

  // angle constants in Q2.13
  localparam logic signed [SUM_W-1:0] PI_Q13 = SUM_W'(25736);
  localparam logic signed [SUM_W-1:0] HALF_PI_Q13 = SUM_W'(12868);
  localparam logic signed [SUM_W-1:0] TWO_PI_Q13 = SUM_W'(51472);
  localparam logic signed [SUM_W-1:0] FOUR_PI_Q13 = SUM_W'(102944);
  localparam logic signed [SUM_W-1:0] THREE_PI_Q13 = SUM_W'(77208);

  localparam longint XY_LIMIT = 49104;
  localparam longint Z_HIGH = 65472;

  // register indexes
  localparam logic [1:0] REG_BASE_HEIGHT = 2'd0;
  localparam logic [1:0] REG_FIRST_LINK = 2'd1;
  localparam logic [1:0] REG_SECOND_LINK = 2'd2;
  localparam logic [1:0] REG_THIRD_LINK = 2'd3;

  // CORDIC start vector: gain-compensated unit x, rounded to Q(ANGLE_BITS)
  localparam logic signed [CW-1:0] GAIN_X =
    CW'((longint'(652032874) + (longint'(1) << (29 - ANGLE_BITS))) >>> (30 - ANGLE_BITS));

  // arctan(2^-i) rounded from Q30 to Q(ANGLE_BITS)
  function automatic logic signed [CW-1:0] atan_step(input int i);
    longint q30;
    unique case (i)
      0:  q30 = 843314857;
      1:  q30 = 497837829;
      2:  q30 = 263043837;
      3:  q30 = 133525159;
      4:  q30 = 67021687;
      5:  q30 = 33543516;
      6:  q30 = 16775851;
      7:  q30 = 8388437;
      8:  q30 = 4194283;
      9:  q30 = 2097149;
      default: q30 = longint'(1) << (30 - i);
    endcase
    return CW'((q30 + (longint'(1) << (29 - ANGLE_BITS))) >>> (30 - ANGLE_BITS));
  endfunction

endpackage

### src/afk_sincos.sv
// Pipelined rotation-mode CORDIC giving sine and cosine of a Q2.13 angle.
module afk_sincos (
  input  logic                             clk,
  input  logic [afk_pkg::SC_STAGES-1:0]    en,
  input  logic signed [afk_pkg::SUM_W-1:0] angle,
  output logic signed [afk_pkg::CW-1:0]    sin_out,
  output logic signed [afk_pkg::CW-1:0]    cos_out
);
  import afk_pkg::*;

  logic signed [SUM_W-1:0] wrapped;
  logic signed [SUM_W-1:0] folded;
  logic                    fold_neg;
  logic [SUM_W-1:0]        mag;
  logic [SUM_W+ANGLE_BITS:0] zwide;
  logic signed [CW-1:0]    zstart;

  logic signed [CW-1:0] xr [ANGLE_BITS+1];
  logic signed [CW-1:0] yr [ANGLE_BITS+1];
  logic signed [CW-1:0] zr [ANGLE_BITS+1];
  logic                 ng [ANGLE_BITS+1];

  // wrap into [-pi, pi) and fold into [-pi/2, pi/2]
  always_comb begin
    if (angle >= THREE_PI_Q13) begin
      wrapped = angle - FOUR_PI_Q13;
    end else if (angle >= PI_Q13) begin
      wrapped = angle - TWO_PI_Q13;
    end else if (angle < -THREE_PI_Q13) begin
      wrapped = angle + FOUR_PI_Q13;
    end else if (angle < -PI_Q13) begin
      wrapped = angle + TWO_PI_Q13;
    end else begin
      wrapped = angle;
    end
    if (wrapped > HALF_PI_Q13) begin
      folded = wrapped - PI_Q13;
      fold_neg = 1'b1;
    end else if (wrapped < -HALF_PI_Q13) begin
      folded = wrapped + PI_Q13;
      fold_neg = 1'b1;
    end else begin
      folded = wrapped;
      fold_neg = 1'b0;
    end
    mag = folded[SUM_W-1] ? SUM_W'(-folded) : SUM_W'(folded);
    zwide = (({(ANGLE_BITS+1)'(0), mag} << ANGLE_BITS) + (SUM_W+ANGLE_BITS+1)'(4096)) >> 13;
    zstart = folded[SUM_W-1] ? -CW'(zwide) : CW'(zwide);
  end

  // fold stage register
  always_ff @(posedge clk) begin
    if (en[0]) begin
      zr[0] <= zstart;
      ng[0] <= fold_neg;
    end
  end

  assign xr[0] = GAIN_X;
  assign yr[0] = '0;

  // one micro-rotation per stage
  for (genvar i = 0; i < ANGLE_BITS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        if (!zr[i][CW-1]) begin
          xr[i+1] <= xr[i] - (yr[i] >>> i);
          yr[i+1] <= yr[i] + (xr[i] >>> i);
          zr[i+1] <= zr[i] - atan_step(i);
        end else begin
          xr[i+1] <= xr[i] + (yr[i] >>> i);
          yr[i+1] <= yr[i] - (xr[i] >>> i);
          zr[i+1] <= zr[i] + atan_step(i);
        end
        ng[i+1] <= ng[i];
      end
    end
  end

  assign sin_out = ng[ANGLE_BITS] ? -yr[ANGLE_BITS] : yr[ANGLE_BITS];
  assign cos_out = ng[ANGLE_BITS] ? -xr[ANGLE_BITS] : xr[ANGLE_BITS];

endmodule

### src/arm_forward_kinematics.sv
// Top level: forward kinematics pipeline of a four-joint arm with APB registers.
// Throughput: one item per cycle while out_ready holds; each stage holds one item and shifts when free.
// The depth is set by the CORDIC, one micro-rotation per stage, four units in parallel.
// Reset clears all stage valid bits and loads the registers with 153, 121, 121, 150.
// Stalls propagate back combinationally through the full stages; bubbles are squeezed out.
module arm_forward_kinematics (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [afk_pkg::IN_W-1:0]  base_angle,
  input  logic signed [afk_pkg::IN_W-1:0]  shoulder_angle,
  input  logic signed [afk_pkg::IN_W-1:0]  elbow_angle,
  input  logic signed [afk_pkg::IN_W-1:0]  wrist_angle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [afk_pkg::OUT_W-1:0] pos_x,
  output logic signed [afk_pkg::OUT_W-1:0] pos_y,
  output logic signed [afk_pkg::OUT_W-1:0] pos_z,
  output logic signed [afk_pkg::OUT_W-1:0] reach
);
  import afk_pkg::*;

  localparam int SD = ANGLE_BITS + 2;  // products
  localparam int SE = ANGLE_BITS + 3;  // sums
  localparam int SF = ANGLE_BITS + 4;  // final multiply
  localparam int SG = ANGLE_BITS + 5;  // round and clamp

  function automatic logic signed [OUT_W-1:0] sat(input longint v, input longint lo,
                                                  input longint hi);
    longint r;
    r = (v < lo) ? lo : ((v > hi) ? hi : v);
    return OUT_W'(r);
  endfunction

  logic [LEN_W-1:0] base_height, first_link_length, second_link_length, third_link_length;

  logic [NSTAGES-1:0] v;
  logic [NSTAGES-1:0] en;

  logic signed [SUM_W-1:0] t0, t1, t12, t123;
  logic signed [CW-1:0] s0, c0, s1, c1, s12, c12, s123, c123;

  logic signed [PROD_W-1:0] pc1, pc12, pc123, ps1, ps12, ps123;
  logic signed [CW-1:0]     d_ns0, d_c0;
  logic signed [RS_W-1:0]   rs, zs;
  logic signed [CW-1:0]     e_ns0, e_c0;
  logic signed [PXY_W-1:0]  prx, pry;
  logic signed [RS_W-1:0]   f_reach;
  logic signed [RS_W:0]     f_z;

  // APB register file
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      base_height <= LEN_W'(153);
      first_link_length <= LEN_W'(121);
      second_link_length <= LEN_W'(121);
      third_link_length <= LEN_W'(150);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_BASE_HEIGHT: base_height <= pwdata[LEN_W-1:0];
        REG_FIRST_LINK:  first_link_length <= pwdata[LEN_W-1:0];
        REG_SECOND_LINK: second_link_length <= pwdata[LEN_W-1:0];
        REG_THIRD_LINK:  third_link_length <= pwdata[LEN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BASE_HEIGHT: prdata = 32'(base_height);
      REG_FIRST_LINK:  prdata = 32'(first_link_length);
      REG_SECOND_LINK: prdata = 32'(second_link_length);
      REG_THIRD_LINK:  prdata = 32'(third_link_length);
    endcase
  end

  // stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en[NSTAGES-1] = !v[NSTAGES-1] || out_ready;
    for (int k = NSTAGES - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end
  assign in_ready = en[0];
  assign out_valid = v[NSTAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < NSTAGES; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // input stage: base angle and cumulative pitch sums
  always_ff @(posedge clk) begin
    if (en[0]) begin
      t0 <= SUM_W'(base_angle);
      t1 <= SUM_W'(shoulder_angle);
      t12 <= SUM_W'(shoulder_angle) + SUM_W'(elbow_angle);
      t123 <= SUM_W'(shoulder_angle) + SUM_W'(elbow_angle) + SUM_W'(wrist_angle);
    end
  end

  afk_sincos u_sc0 (.clk, .en(en[SC_STAGES:1]), .angle(t0), .sin_out(s0), .cos_out(c0));
  afk_sincos u_sc1 (.clk, .en(en[SC_STAGES:1]), .angle(t1), .sin_out(s1), .cos_out(c1));
  afk_sincos u_sc2 (.clk, .en(en[SC_STAGES:1]), .angle(t12), .sin_out(s12), .cos_out(c12));
  afk_sincos u_sc3 (.clk, .en(en[SC_STAGES:1]), .angle(t123), .sin_out(s123),
                    .cos_out(c123));

  // link products
  always_ff @(posedge clk) begin
    if (en[SD]) begin
      pc1   <= signed'({1'b0, first_link_length}) * c1;
      pc12  <= signed'({1'b0, second_link_length}) * c12;
      pc123 <= signed'({1'b0, third_link_length}) * c123;
      ps1   <= signed'({1'b0, first_link_length}) * s1;
      ps12  <= signed'({1'b0, second_link_length}) * s12;
      ps123 <= signed'({1'b0, third_link_length}) * s123;
      d_ns0 <= -s0;
      d_c0  <= c0;
    end
  end

  // reach and height sums
  always_ff @(posedge clk) begin
    if (en[SE]) begin
      rs <= RS_W'(pc1) + RS_W'(pc12) + RS_W'(pc123);
      zs <= RS_W'(ps1) + RS_W'(ps12) + RS_W'(ps123);
      e_ns0 <= d_ns0;
      e_c0 <= d_c0;
    end
  end

  // base rotation products, scaling of reach and height, and base height offset
  always_ff @(posedge clk) begin
    if (en[SF]) begin
      prx <= PXY_W'(e_ns0) * PXY_W'(rs);
      pry <= PXY_W'(e_c0) * PXY_W'(rs);
      f_reach <= (rs + RS_W'(longint'(1) << (ANGLE_BITS - 5))) >>> (ANGLE_BITS - 4);
      f_z <= (RS_W+1)'({base_height, 4'b0000})
             + (RS_W+1)'((zs + RS_W'(longint'(1) << (ANGLE_BITS - 5))) >>> (ANGLE_BITS - 4));
    end
  end

  // rounding and saturation into the output register
  always_ff @(posedge clk) begin
    if (en[SG]) begin
      pos_x <= sat(longint'((prx + PXY_W'(longint'(1) << (2*ANGLE_BITS - 5)))
                             >>> (2*ANGLE_BITS - 4)), -XY_LIMIT, XY_LIMIT);
      pos_y <= sat(longint'((pry + PXY_W'(longint'(1) << (2*ANGLE_BITS - 5)))
                             >>> (2*ANGLE_BITS - 4)), -XY_LIMIT, XY_LIMIT);
      pos_z <= sat(longint'(f_z), -XY_LIMIT, Z_HIGH);
      reach <= sat(longint'(f_reach), -XY_LIMIT, XY_LIMIT);
    end
  end

  // the input stage refuses new data only while it holds an item
  a_stall_holds: assert property (@(posedge clk) disable iff (rst) !en[0] |-> v[0])
    else $error("input stage stalled while empty");
  // a bubble entering the last stage leaves no result
  a_bubble_out: assert property (@(posedge clk) disable iff (rst)
    en[SG] && !v[SF] |=> !out_valid)
    else $error("result invented from a bubble");
  // a stalled sum stage keeps its item
  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    v[SE] && !en[SE] |=> v[SE] && $stable(rs) && $stable(zs))
    else $error("stalled sum stage changed");

endmodule
